### sv/nsd_pkg.sv
// Package for the netstring deframer: phase and verdict codes, byte constants
// and stream word widths. Depends on nothing; used by netstring_deframer_top.
package nsd_pkg;

    // Parse phase of the current buffer
    typedef enum logic [1:0] {
        PH_DIGITS = 2'd0,
        PH_BODY   = 2'd1,
        PH_SKIP   = 2'd2
    } t_phase;

    // Frame verdict codes; ST_NONE marks "no verdict yet"
    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_TOO_SHORT    = 3'd1,
        ST_TOO_LONG     = 3'd2,
        ST_NO_COLON     = 3'd3,
        ST_NO_COMMA     = 3'd4,
        ST_LEADING_ZERO = 3'd5,
        ST_NO_LENGTH    = 3'd6,
        ST_NONE         = 3'd7
    } t_status;

    // Framing characters
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;

    // Stream word layout
    localparam int unsigned IN_TDATA_W    = 8;
    localparam int unsigned PAY_LEN_W     = 30;
    localparam int unsigned OUT_FIELDS_W  = 1 + 8 + 1 + 3 + PAY_LEN_W;
    localparam int unsigned OUT_TDATA_W   = 48;
    localparam int unsigned OUT_PAD_W     = OUT_TDATA_W - OUT_FIELDS_W;

    // Short buffer limit: byte index below which a buffer end means too short
    localparam logic [1:0] MIN_IDX       = 2'd2;
    localparam logic [1:0] BYTES_SAT     = 2'd3;

endpackage

### sv/netstring_deframer_top.sv
// Netstring deframer: parses "<len>:<payload>," from a byte stream, one byte
// per word, and gives one result word per input word. Uses nsd_pkg.
//
// Usage:
//   Slave channel (i_s_*): one buffer byte per word, tlast on its last byte.
//   Master channel (o_m_*): one result word per input word, in order. It
//   carries a payload byte with a valid mark, or the buffer's verdict
//   (frame_done with status and decoded length), or all zeros.
//   Each accepted byte's result word is registered in the result register.
//   Throughput is one word per cycle while the master side takes each word;
//   the result register is the only stage, and the slave side is ready
//   whenever that register is empty or is being taken in the same cycle.
//   A stall on the master side holds the result word and stops intake until
//   it is taken; no word is dropped or repeated.
//   Reset (i_rst_n low at a clock edge) empties the result register and
//   starts a new buffer in the length digits phase.
//   After a verdict the remaining bytes of the buffer yield zero words; the
//   byte after tlast starts a new buffer.
module netstring_deframer_top #(
    parameter int unsigned MAX_LENGTH_DIGITS = 9
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Slave stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [nsd_pkg::IN_TDATA_W-1:0]  i_s_tdata,   // [7:0] data_byte
    input  logic                            i_s_tlast,   // buffer_end
    // Master stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [0] payload_valid, [8:1] payload_byte, [9] frame_done,
    // [12:10] status, [42:13] payload_length, [47:43] zero
    output logic [nsd_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    // Accumulator wide enough for MAX_LENGTH_DIGITS decimal digits
    localparam int unsigned LEN_W = (MAX_LENGTH_DIGITS * 10 + 2) / 3;
    localparam int unsigned ACC_W = (LEN_W > nsd_pkg::PAY_LEN_W) ? LEN_W : nsd_pkg::PAY_LEN_W;
    localparam int unsigned CNT_W = $clog2(MAX_LENGTH_DIGITS + 1);

    // Parse state
    nsd_pkg::t_phase  r_phase,   n_phase;
    nsd_pkg::t_status r_pend,    n_pend;
    logic [ACC_W-1:0] r_acc,     n_acc;
    logic [ACC_W-1:0] r_rem,     n_rem;
    logic [CNT_W-1:0] r_cnt,     n_cnt;
    logic [1:0]       r_bytes,   n_bytes;
    logic             r_fzero,   n_fzero;

    // Result register
    logic                             r_out_valid;
    logic                             r_pv;
    logic [7:0]                       r_pb;
    logic                             r_done;
    nsd_pkg::t_status                 r_status;
    logic [nsd_pkg::PAY_LEN_W-1:0]    r_len;

    // Combinational result of the current byte
    nsd_pkg::t_status                 verdict;
    logic                             c_pv;
    logic [7:0]                       c_pb;
    logic                             c_done;
    nsd_pkg::t_status                 c_status;
    logic [nsd_pkg::PAY_LEN_W-1:0]    c_len;
    logic                             is_digit;
    logic [3:0]                       digit;
    logic                             s_accept;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_accept   = i_s_tvalid && o_s_tready;

    assign is_digit = i_s_tdata inside {[nsd_pkg::CHAR_ZERO:nsd_pkg::CHAR_NINE]};
    assign digit    = i_s_tdata[3:0];

    // Next state and result of one byte
    always_comb begin
        n_phase = r_phase;
        n_pend  = r_pend;
        n_acc   = r_acc;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_fzero = r_fzero;
        verdict = nsd_pkg::ST_NONE;
        c_pv    = 1'b0;
        c_pb    = '0;

        case (r_phase)
            nsd_pkg::PH_DIGITS: begin
                if (r_pend != nsd_pkg::ST_NONE) begin
                    verdict = r_pend;
                end else if (r_bytes == 2'd0) begin
                    if (!is_digit) begin
                        n_pend = nsd_pkg::ST_NO_LENGTH;
                    end else begin
                        n_fzero = (i_s_tdata == nsd_pkg::CHAR_ZERO);
                        n_acc   = ACC_W'(digit);
                        n_cnt   = CNT_W'(1);
                    end
                end else if (is_digit) begin
                    if (r_bytes == 2'd1 && r_fzero) begin
                        verdict = nsd_pkg::ST_LEADING_ZERO;
                    end else if (r_cnt >= CNT_W'(MAX_LENGTH_DIGITS)) begin
                        verdict = nsd_pkg::ST_TOO_LONG;
                    end else begin
                        // times ten as shift and add
                        n_acc = (r_acc << 3) + (r_acc << 1) + ACC_W'(digit);
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end else begin
                    n_pend  = (i_s_tdata == nsd_pkg::CHAR_COLON) ? nsd_pkg::ST_NONE
                                                                 : nsd_pkg::ST_NO_COLON;
                    n_rem   = r_acc;
                    n_phase = nsd_pkg::PH_BODY;
                end
            end
            nsd_pkg::PH_BODY: begin
                if (r_rem != '0) begin
                    // pass payload unless a missing colon is pending
                    if (r_pend == nsd_pkg::ST_NONE) begin
                        c_pv = 1'b1;
                        c_pb = i_s_tdata;
                    end
                    n_rem = r_rem - ACC_W'(1);
                end else if (r_pend != nsd_pkg::ST_NONE) begin
                    verdict = r_pend;
                end else begin
                    verdict = (i_s_tdata == nsd_pkg::CHAR_COMMA) ? nsd_pkg::ST_OK
                                                                 : nsd_pkg::ST_NO_COMMA;
                end
            end
            default: begin
            end
        endcase

        // Buffer end before a verdict, or a short buffer, overrides
        if (r_phase != nsd_pkg::PH_SKIP && i_s_tlast &&
            (verdict == nsd_pkg::ST_NONE || r_bytes < nsd_pkg::MIN_IDX)) begin
            verdict = nsd_pkg::ST_TOO_SHORT;
        end

        c_done   = (verdict != nsd_pkg::ST_NONE);
        c_status = nsd_pkg::ST_OK;
        c_len    = '0;
        if (c_done) begin
            c_pv     = 1'b0;
            c_pb     = '0;
            c_status = verdict;
            n_phase  = nsd_pkg::PH_SKIP;
            if (verdict == nsd_pkg::ST_OK) begin
                c_len = r_acc[nsd_pkg::PAY_LEN_W-1:0];
            end
        end

        n_bytes = (r_bytes < nsd_pkg::BYTES_SAT) ? r_bytes + 2'd1 : r_bytes;

        // Start afresh after the buffer's last byte
        if (i_s_tlast) begin
            n_phase = nsd_pkg::PH_DIGITS;
            n_pend  = nsd_pkg::ST_NONE;
            n_acc   = '0;
            n_rem   = '0;
            n_cnt   = '0;
            n_bytes = '0;
            n_fzero = 1'b0;
        end
    end

    // Advance parse state on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= nsd_pkg::PH_DIGITS;
            r_pend  <= nsd_pkg::ST_NONE;
            r_acc   <= '0;
            r_rem   <= '0;
            r_cnt   <= '0;
            r_bytes <= '0;
            r_fzero <= 1'b0;
        end else if (s_accept) begin
            r_phase <= n_phase;
            r_pend  <= n_pend;
            r_acc   <= n_acc;
            r_rem   <= n_rem;
            r_cnt   <= n_cnt;
            r_bytes <= n_bytes;
            r_fzero <= n_fzero;
        end
    end

    // Hold the result word until the master side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_pv     <= c_pv;
            r_pb     <= c_pb;
            r_done   <= c_done;
            r_status <= c_status;
            r_len    <= c_len;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{nsd_pkg::OUT_PAD_W{1'b0}}, r_len, r_status, r_done, r_pb, r_pv};

`ifndef SYNTHESIS
    // A verdict word never also carries a payload byte
    a_done_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_done && r_pv))
        else $error("verdict word carries a payload byte");

    // Status and length are zero unless a verdict is given, length only when ok
    a_len_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_len != '0) |-> (r_done && r_status == nsd_pkg::ST_OK))
        else $error("payload length outside an ok verdict");

    // Bytes skipped after a verdict give no payload and no second verdict
    a_skip_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && r_phase == nsd_pkg::PH_SKIP) |=> (!r_pv && !r_done))
        else $error("output during skip phase");

    // Every buffer ends with exactly one verdict unless one was already given
    a_end_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_s_tlast && r_phase != nsd_pkg::PH_SKIP) |=> r_done)
        else $error("buffer ended without a verdict");

    // A buffer always restarts in the digits phase
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_s_tlast) |=> (r_phase == nsd_pkg::PH_DIGITS && r_bytes == 2'd0))
        else $error("buffer did not restart");
`endif

endmodule
